@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
package tcw_pkg;

    // Field widths of the input and result words
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    // APB register file geometry
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_TEXT_COLOR = 2'd0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes with special meaning
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_address;
    } t_in_word;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_position;
        logic [CELL_W-1:0]   cell_value;
    } t_out_word;

endpackage

@@ rtl/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// Top level of the text console writer: register file, sequencer, result register.
//
// Keeps a COLUMNS x ROWS screen of 16-bit cells (attribute high byte, character low
// byte) in one synchronous RAM, plus a cursor. One word is worked on at a time.
// After reset the block fills the screen RAM with blanks of attribute 0x07, one
// cell a cycle, before o_in_ready rises; APB writes are taken during that time. A
// put of a character, newline or backspace goes through the put state; a read of
// one cell takes one RAM read, while an out-of-range address or an unused operation
// code goes straight to the result; clear screen blanks every cell and homes the
// cursor; a put that must scroll first moves every cell below the top row up one
// row through the single RAM read port and then blanks the last row. A finished
// result sits in an output register, so the next word is accepted while it waits
// to be taken.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tcw_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tcw_pkg::t_out_word           o_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] text_color;
    logic              res_valid;
    logic              res_ready;
    t_out_word         res_word;

    logic              r_out_valid;
    t_out_word         r_out_word;

    tcw_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_text_color (text_color)
    );

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (text_color),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res_word)
    );

    // Take a new result when the output register is empty or being drained
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // A result is never dropped: a pending result only loads when room exists
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && r_out_valid && !i_out_ready) |=> res_valid)
        else $error("result lost while output register full");

    // Input is never taken while the sequencer offers a result
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && res_valid))
        else $error("input accepted during result handoff");

endmodule

@@ rtl/tcw_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, and register the entry read at i_raddr
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tcw_apb.sv @@
`timescale 1ns / 1ps
// APB register file holding the text color attribute.
module tcw_apb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [tcw_pkg::ATTR_W-1:0]   o_text_color
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] r_text_color;
    logic              wr_en;

    // Write in the access phase, ignore unmapped addresses
    assign wr_en = psel && penable && pwrite && (paddr == ADDR_TEXT_COLOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_ATTR;
        end else if (wr_en) begin
            r_text_color <= pwdata[ATTR_W-1:0];
        end
    end

    // Read back the register, zero elsewhere
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_TEXT_COLOR) begin
            prdata = PDATA_W'(r_text_color);
        end
    end

    assign pready       = 1'b1;
    assign o_text_color = r_text_color;

endmodule

@@ rtl/tcw_seq.sv @@
`timescale 1ns / 1ps
// Sequencer: cursor state and read-modify-write sweeps over the screen memory.
module tcw_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0] i_text_color,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tcw_pkg::t_in_word          i_in_word,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output tcw_pkg::t_out_word         o_res
);
    import tcw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int LAST_ROW = COLUMNS * (ROWS - 1);
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(CELLS + 1);
    localparam int COLW     = $clog2(COLUMNS);

    localparam logic [AW-1:0]     LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0]     LAST_MOVE  = AW'(LAST_ROW - 1);
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL_MOVE,
        S_SCROLL_FILL,
        S_PUT,
        S_CLEAR,
        S_READ,
        S_DONE
    } t_state;

    t_state              r_state,  n_state;
    logic [AW-1:0]       r_ptr,    n_ptr;
    logic                r_pend,   n_pend;
    logic [CW-1:0]       r_cursor, n_cursor;
    logic [COLW-1:0]     r_col,    n_col;
    logic [CHAR_W-1:0]   r_char,   n_char;
    logic [CELL_W-1:0]   r_value,  n_value;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [CELL_W-1:0]   mem_rdata;

    logic [CELL_W-1:0]   blank_cell;
    logic [CW-1:0]       cursor_m1;
    logic [AW-1:0]       ptr_m1;
    logic                addr_ok;

    assign blank_cell = {i_text_color, CH_BLANK};
    assign cursor_m1  = r_cursor - 1'b1;
    assign ptr_m1     = r_ptr - 1'b1;
    assign addr_ok    = 32'(i_in_word.cell_address) < 32'(CELLS);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Next state, memory port and cursor update
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_pend    = r_pend;
        n_cursor  = r_cursor;
        n_col     = r_col;
        n_char    = r_char;
        n_value   = r_value;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = blank_cell;
        mem_raddr = AW'(i_in_word.cell_address);

        unique case (r_state)
            S_INIT: begin
                // Fill every cell with the reset blank
                mem_we    = 1'b1;
                mem_wdata = RESET_CELL;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_char  = i_in_word.char_code;
                    n_value = '0;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    unique case (i_in_word.operation)
                        OP_PUT: begin
                            n_state = (r_cursor == CW'(CELLS)) ? S_SCROLL_MOVE : S_PUT;
                        end
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_READ:  n_state = addr_ok ? S_READ : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SCROLL_MOVE: begin
                // Read one row down, write the previous read one row up
                mem_raddr = r_ptr + AW'(COLUMNS);
                mem_we    = r_pend;
                mem_waddr = ptr_m1;
                mem_wdata = mem_rdata;
                n_pend    = 1'b1;
                n_ptr     = r_ptr + 1'b1;
                if (r_ptr == LAST_MOVE) begin
                    n_state = S_SCROLL_FILL;
                end
            end
            S_SCROLL_FILL: begin
                mem_we = 1'b1;
                if (r_pend) begin
                    // Drain the last moved cell
                    mem_waddr = ptr_m1;
                    mem_wdata = mem_rdata;
                    n_pend    = 1'b0;
                end else if (r_ptr == LAST_CELL) begin
                    n_ptr    = '0;
                    n_cursor = CW'(LAST_ROW);
                    n_col    = '0;
                    n_state  = S_PUT;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_PUT: begin
                n_state = S_DONE;
                case (r_char)
                    CH_NEWLINE: begin
                        n_cursor = r_cursor - CW'(r_col) + CW'(COLUMNS);
                        n_col    = '0;
                    end
                    CH_BACKSPACE: begin
                        if (r_cursor != '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = cursor_m1[AW-1:0];
                            n_cursor  = cursor_m1;
                            n_col     = (r_col == '0) ? COLW'(COLUMNS - 1) : r_col - 1'b1;
                        end
                    end
                    default: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cursor[AW-1:0];
                        mem_wdata = {i_text_color, r_char};
                        n_cursor  = r_cursor + 1'b1;
                        n_col     = (r_col == COLW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
                    end
                endcase
            end
            S_CLEAR: begin
                // Blank the screen and home the cursor
                mem_we = 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_ptr    = '0;
                    n_cursor = '0;
                    n_col    = '0;
                    n_state  = S_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_READ: begin
                n_value = mem_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ptr    <= '0;
            r_pend   <= 1'b0;
            r_cursor <= '0;
            r_col    <= '0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            r_cursor <= n_cursor;
            r_col    <= n_col;
        end
        r_char  <= n_char;
        r_value <= n_value;
    end

    assign o_in_ready            = (r_state == S_IDLE);
    assign o_res_valid           = (r_state == S_DONE);
    assign o_res.cursor_position = CURSOR_W'(r_cursor);
    assign o_res.cell_value      = r_value;

    // Cursor never runs past one beyond the last cell
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CW'(CELLS))
        else $error("cursor beyond screen");

    // Column tracker stays inside a row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(COLUMNS))
        else $error("column out of range");

    // A character is only stored once the cursor is on screen
    a_put_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_cursor < CW'(CELLS)))
        else $error("put with cursor off screen");

    // A scroll always lands the cursor on the last row start
    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL_FILL && !r_pend && r_ptr == LAST_CELL)
        |=> (r_cursor == CW'(LAST_ROW)))
        else $error("scroll left cursor misplaced");

endmodule
